// ===== hdl/sfps_pkg.sv =====
// shared types, codes and constants of the spi flash erase/program sequencer
package sfps_pkg;

  localparam int PAGE_BYTES = 256;
  localparam int MAX_RES    = 5;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  localparam logic [1:0] REG_TOP_SMALL  = 2'd0;
  localparam logic [1:0] REG_ERASE_POLL = 2'd1;
  localparam logic [1:0] REG_PROG_POLL  = 2'd2;

  localparam logic [20:0] ERASE_POLL_RESET = 21'd2000000;
  localparam logic [19:0] PROG_POLL_RESET  = 20'd1000000;

  localparam logic [2:0] ERR_OK            = 3'd0;
  localparam logic [2:0] ERR_ERASE_FAIL    = 3'd1;
  localparam logic [2:0] ERR_ERASE_TIMEOUT = 3'd2;
  localparam logic [2:0] ERR_PROG_FAIL     = 3'd3;
  localparam logic [2:0] ERR_PROG_TIMEOUT  = 3'd4;

  localparam logic [7:0] OP_WREN      = 8'h06;
  localparam logic [7:0] OP_RDSR      = 8'h05;
  localparam logic [7:0] OP_ERASE_4K  = 8'h20;
  localparam logic [7:0] OP_ERASE_64K = 8'hD8;
  localparam logic [7:0] OP_PROGRAM   = 8'h02;
  localparam logic [7:0] OP_ERS_SUSP  = 8'h75;
  localparam logic [7:0] OP_PGM_SUSP  = 8'h85;
  localparam logic [7:0] OP_CLSR      = 8'h30;

  localparam logic [7:0] ERASE_BUSY_MASK = 8'h21;
  localparam logic [7:0] ERASE_FAIL_BIT  = 8'h20;
  localparam logic [7:0] PROG_BUSY_MASK  = 8'h41;
  localparam logic [7:0] PROG_FAIL_BIT   = 8'h40;

  localparam logic [23:0] SMALL_LOW_END    = 24'h020000;
  localparam logic [23:0] SMALL_HIGH_START = 24'hFE0000;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] start_address;
    logic [24:0] byte_count;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic        top_small_sectors;
    logic [20:0] erase_poll_limit;
    logic [19:0] program_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic       spi_valid;
    logic [7:0] spi_byte;
    logic       frame_end;
    logic       reply_wanted;
  } ent_t;

  typedef struct packed {
    ent_t [MAX_RES-1:0] ent;
    logic [2:0]         count;
    logic               done;
    logic [2:0]         err;
  } burst_t;

  function automatic ent_t mk(logic v, logic [7:0] b, logic fe, logic rw);
    ent_t e;
    e.spi_valid    = v;
    e.spi_byte     = b;
    e.frame_end    = fe;
    e.reply_wanted = rw;
    return e;
  endfunction

endpackage

// ===== hdl/sfps_cfg.sv =====
// configuration register file
module sfps_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [20:0]      cfg_data,
  output sfps_pkg::cfg_t   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_small_sectors  <= 1'b0;
      cfg.erase_poll_limit   <= sfps_pkg::ERASE_POLL_RESET;
      cfg.program_poll_limit <= sfps_pkg::PROG_POLL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sfps_pkg::REG_TOP_SMALL:  cfg.top_small_sectors  <= cfg_data[0];
        sfps_pkg::REG_ERASE_POLL: cfg.erase_poll_limit   <= cfg_data;
        sfps_pkg::REG_PROG_POLL:  cfg.program_poll_limit <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/sfps_fsm.sv =====
// sequencer state and the burst of spi words that one input word causes
module sfps_fsm #(
  parameter int PAGE_BYTES = sfps_pkg::PAGE_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  sfps_pkg::item_t    item,
  input  sfps_pkg::cfg_t     cfg,
  output sfps_pkg::burst_t   bst
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_WREN_ERASE, PH_ERASE_POLL, PH_WREN_PROG, PH_PROG_DATA, PH_PROG_POLL
  } phase_t;

  phase_t      phase, phase_next;
  logic [23:0] current_address, address_next;
  logic [24:0] bytes_remaining, remaining_next;
  logic        sector_is_small, small_next;
  logic [8:0]  page_length, page_length_next;
  logic [8:0]  page_sent, page_sent_next;
  logic [20:0] poll_count, poll_next;

  logic [2:0]  n;
  logic        do_page;
  logic [23:0] pg_addr;
  logic [24:0] pg_rem;
  logic        pg_small;
  logic        start_small;
  logic [20:0] poll_inc;
  logic [8:0]  sent_inc;
  logic [23:0] sum_addr;
  logic [24:0] diff_rem;

  always_comb begin
    phase_next       = phase;
    address_next     = current_address;
    remaining_next   = bytes_remaining;
    small_next       = sector_is_small;
    page_length_next = page_length;
    page_sent_next   = page_sent;
    poll_next        = poll_count;
    bst              = '0;
    n                = 3'd0;
    do_page          = 1'b0;
    pg_addr          = current_address;
    pg_rem           = bytes_remaining;
    pg_small         = sector_is_small;
    poll_inc         = poll_count + 21'd1;
    sent_inc         = page_sent + 9'd1;
    sum_addr         = current_address + {15'd0, page_length};
    diff_rem         = bytes_remaining - {16'd0, page_length};
    start_small      = cfg.top_small_sectors ?
                       (item.start_address >= sfps_pkg::SMALL_HIGH_START) :
                       (item.start_address < sfps_pkg::SMALL_LOW_END);

    case (item.command)
      sfps_pkg::CMD_START: begin
        if (phase == PH_IDLE) begin
          address_next   = item.start_address;
          remaining_next = item.byte_count;
          small_next     = start_small;
          if (item.byte_count == 25'd0) begin
            bst.ent[0] = sfps_pkg::mk(1'b0, 8'd0, 1'b0, 1'b0);
            n          = 3'd1;
            bst.done   = 1'b1;
          end else begin
            do_page  = 1'b1;
            pg_addr  = item.start_address;
            pg_rem   = item.byte_count;
            pg_small = start_small;
          end
        end
      end
      sfps_pkg::CMD_DATA: begin
        if (phase == PH_PROG_DATA) begin
          page_sent_next = sent_inc;
          if (sent_inc >= page_length) begin
            bst.ent[0] = sfps_pkg::mk(1'b1, item.payload_byte, 1'b1, 1'b0);
            bst.ent[1] = sfps_pkg::mk(1'b1, sfps_pkg::OP_RDSR, 1'b0, 1'b1);
            n          = 3'd2;
            poll_next  = '0;
            phase_next = PH_PROG_POLL;
          end else begin
            bst.ent[0] = sfps_pkg::mk(1'b1, item.payload_byte, 1'b0, 1'b0);
            n          = 3'd1;
          end
        end
      end
      sfps_pkg::CMD_STATUS: begin
        case (phase)
          PH_WREN_ERASE: begin
            bst.ent[0] = sfps_pkg::mk(1'b1, sector_is_small ? sfps_pkg::OP_ERASE_4K :
                                      sfps_pkg::OP_ERASE_64K, 1'b0, 1'b0);
            bst.ent[1] = sfps_pkg::mk(1'b1, current_address[23:16], 1'b0, 1'b0);
            bst.ent[2] = sfps_pkg::mk(1'b1, current_address[15:8], 1'b0, 1'b0);
            bst.ent[3] = sfps_pkg::mk(1'b1, current_address[7:0], 1'b1, 1'b0);
            bst.ent[4] = sfps_pkg::mk(1'b1, sfps_pkg::OP_RDSR, 1'b0, 1'b1);
            n          = 3'd5;
            poll_next  = '0;
            phase_next = PH_ERASE_POLL;
          end
          PH_WREN_PROG: begin
            // program opcode and address open the data frame
            bst.ent[0] = sfps_pkg::mk(1'b1, sfps_pkg::OP_PROGRAM, 1'b0, 1'b0);
            bst.ent[1] = sfps_pkg::mk(1'b1, current_address[23:16], 1'b0, 1'b0);
            bst.ent[2] = sfps_pkg::mk(1'b1, current_address[15:8], 1'b0, 1'b0);
            bst.ent[3] = sfps_pkg::mk(1'b1, current_address[7:0], 1'b0, 1'b0);
            n          = 3'd4;
            phase_next = PH_PROG_DATA;
          end
          PH_ERASE_POLL: begin
            if ((item.payload_byte & sfps_pkg::ERASE_BUSY_MASK) == 8'd0) begin
              bst.ent[0] = sfps_pkg::mk(1'b1, sfps_pkg::OP_WREN, 1'b1, 1'b0);
              bst.ent[1] = sfps_pkg::mk(1'b1, sfps_pkg::OP_RDSR, 1'b0, 1'b1);
              n          = 3'd2;
              phase_next = PH_WREN_PROG;
            end else if ((item.payload_byte & sfps_pkg::ERASE_FAIL_BIT) != 8'd0) begin
              bst.ent[0] = sfps_pkg::mk(1'b1, sfps_pkg::OP_CLSR, 1'b1, 1'b0);
              n          = 3'd1;
              phase_next = PH_IDLE;
              bst.done   = 1'b1;
              bst.err    = sfps_pkg::ERR_ERASE_FAIL;
            end else begin
              poll_next = poll_inc;
              if (poll_inc >= cfg.erase_poll_limit) begin
                bst.ent[0] = sfps_pkg::mk(1'b1, sfps_pkg::OP_ERS_SUSP, 1'b1, 1'b0);
                bst.ent[1] = sfps_pkg::mk(1'b1, sfps_pkg::OP_CLSR, 1'b1, 1'b0);
                n          = 3'd2;
                phase_next = PH_IDLE;
                bst.done   = 1'b1;
                bst.err    = sfps_pkg::ERR_ERASE_TIMEOUT;
              end else begin
                bst.ent[0] = sfps_pkg::mk(1'b1, sfps_pkg::OP_RDSR, 1'b0, 1'b1);
                n          = 3'd1;
              end
            end
          end
          PH_PROG_POLL: begin
            if ((item.payload_byte & sfps_pkg::PROG_BUSY_MASK) == 8'd0) begin
              address_next   = sum_addr;
              remaining_next = diff_rem;
              // page covered the whole remainder
              if (bytes_remaining == {16'd0, page_length}) begin
                bst.ent[0] = sfps_pkg::mk(1'b0, 8'd0, 1'b0, 1'b0);
                n          = 3'd1;
                phase_next = PH_IDLE;
                bst.done   = 1'b1;
              end else begin
                do_page  = 1'b1;
                pg_addr  = sum_addr;
                pg_rem   = diff_rem;
              end
            end else if ((item.payload_byte & sfps_pkg::PROG_FAIL_BIT) != 8'd0) begin
              bst.ent[0] = sfps_pkg::mk(1'b1, sfps_pkg::OP_CLSR, 1'b1, 1'b0);
              n          = 3'd1;
              phase_next = PH_IDLE;
              bst.done   = 1'b1;
              bst.err    = sfps_pkg::ERR_PROG_FAIL;
            end else begin
              poll_next = poll_inc;
              if (poll_inc >= {1'b0, cfg.program_poll_limit}) begin
                bst.ent[0] = sfps_pkg::mk(1'b1, sfps_pkg::OP_PGM_SUSP, 1'b1, 1'b0);
                bst.ent[1] = sfps_pkg::mk(1'b1, sfps_pkg::OP_CLSR, 1'b1, 1'b0);
                n          = 3'd2;
                phase_next = PH_IDLE;
                bst.done   = 1'b1;
                bst.err    = sfps_pkg::ERR_PROG_TIMEOUT;
              end else begin
                bst.ent[0] = sfps_pkg::mk(1'b1, sfps_pkg::OP_RDSR, 1'b0, 1'b1);
                n          = 3'd1;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // new page: write enable frame, then status read; erase first on a sector start
    if (do_page) begin
      page_length_next = (pg_rem < 25'(PAGE_BYTES)) ? pg_rem[8:0] : 9'(PAGE_BYTES);
      page_sent_next   = '0;
      bst.ent[n]        = sfps_pkg::mk(1'b1, sfps_pkg::OP_WREN, 1'b1, 1'b0);
      bst.ent[n + 3'd1] = sfps_pkg::mk(1'b1, sfps_pkg::OP_RDSR, 1'b0, 1'b1);
      n                 = n + 3'd2;
      if (pg_small ? (pg_addr[11:0] == 12'd0) : (pg_addr[15:0] == 16'd0)) begin
        phase_next = PH_WREN_ERASE;
      end else begin
        phase_next = PH_WREN_PROG;
      end
    end

    bst.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      current_address <= '0;
      bytes_remaining <= '0;
      sector_is_small <= 1'b0;
      page_length     <= '0;
      page_sent       <= '0;
      poll_count      <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      current_address <= address_next;
      bytes_remaining <= remaining_next;
      sector_is_small <= small_next;
      page_length     <= page_length_next;
      page_sent       <= page_sent_next;
      poll_count      <= poll_next;
    end
  end

endmodule

// ===== hdl/sfps_burst.sv =====
// result buffer: holds one burst of spi words and hands them out one per cycle while out_ready is high
module sfps_burst (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  sfps_pkg::burst_t   bst,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               spi_valid,
  output logic [7:0]         spi_byte,
  output logic               frame_end,
  output logic               reply_wanted,
  output logic               op_done,
  output logic [2:0]         error_code,
  output logic               last_of_run
);

  sfps_pkg::ent_t [sfps_pkg::MAX_RES-1:0] ent;
  logic [2:0] cnt;
  logic       done;
  logic [2:0] err;
  logic       pop;

  assign pop          = out_valid && out_ready;
  assign out_valid    = (cnt != 3'd0);
  assign free         = (cnt == 3'd0) || ((cnt == 3'd1) && out_ready);
  assign spi_valid    = ent[0].spi_valid;
  assign spi_byte     = ent[0].spi_byte;
  assign frame_end    = ent[0].frame_end;
  assign reply_wanted = ent[0].reply_wanted;
  assign last_of_run  = (cnt == 3'd1);
  assign op_done      = done && last_of_run;
  assign error_code   = op_done ? err : sfps_pkg::ERR_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= bst.count;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      ent  <= bst.ent;
      done <= bst.done;
      err  <= bst.err;
    end else if (pop) begin
      for (int i = 0; i < sfps_pkg::MAX_RES - 1; i++) begin
        ent[i] <= ent[i + 1];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(sfps_pkg::MAX_RES))
    else $error("burst count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> ((cnt == 3'd0) || ((cnt == 3'd1) && out_ready)))
    else $error("burst loaded over pending words");

  a_err_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (error_code != sfps_pkg::ERR_OK)) |-> (op_done && last_of_run))
    else $error("error code outside a final word");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !load && (cnt == 3'd2)) |=> last_of_run)
    else $error("burst count did not step down");

endmodule

// ===== hdl/spi_flash_erase_program_sequencer_core.sv =====
// top level of the spi flash erase/program sequencer
//
//  channel  handshake             payload
//  in       in_valid/in_ready     command, start_address, byte_count, payload_byte
//  out      out_valid/out_ready   spi_valid, spi_byte, frame_end, reply_wanted,
//                                 op_done, error_code, last_of_run
//  cfg      cfg_write             cfg_index, cfg_data
//
// an input word is registered, then decoded combinationally into a burst of 0 to 5
// spi words; a burst that is not empty loads the result buffer, and the buffer
// hands out one word per cycle while out_ready is high
// the next input word is taken while the buffer still drains
// reset is synchronous and clears sequencer state and restores register defaults
module spi_flash_erase_program_sequencer_core #(
  parameter int PAGE_BYTES = sfps_pkg::PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [23:0] start_address,
  input  logic [24:0] byte_count,
  input  logic [7:0]  payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        spi_valid,
  output logic [7:0]  spi_byte,
  output logic        frame_end,
  output logic        reply_wanted,
  output logic        op_done,
  output logic [2:0]  error_code,
  output logic        last_of_run
);

  sfps_pkg::cfg_t   cfg;
  sfps_pkg::item_t  item;
  sfps_pkg::burst_t bst;
  logic             in_full;
  logic             free;
  logic             fire;

  assign fire     = in_full && free;
  assign in_ready = !in_full || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.command       <= command;
      item.start_address <= start_address;
      item.byte_count    <= byte_count;
      item.payload_byte  <= payload_byte;
    end
  end

  sfps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfps_fsm #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_fsm (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .bst  (bst)
  );

  sfps_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .load         (fire && (bst.count != 3'd0)),
    .bst          (bst),
    .free         (free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .spi_valid    (spi_valid),
    .spi_byte     (spi_byte),
    .frame_end    (frame_end),
    .reply_wanted (reply_wanted),
    .op_done      (op_done),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

endmodule
